// ===== rtl/qlu_pkg.sv =====
// shared types, codes and constants of the quoted literal unescaper
package qlu_pkg;

	localparam logic [7:0] QUOTE_CH = 8'h27;
	localparam logic [7:0] HASH_CH  = 8'h23;
	localparam logic [7:0] DIGIT_LO = 8'h30;
	localparam logic [7:0] DIGIT_HI = 8'h39;
	localparam logic [11:0] CODE_MAX = 12'd255;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam int RESULT_DEPTH = 4;

	typedef enum logic [2:0] {
		MODE_OPEN  = 3'd0,
		MODE_BODY  = 3'd1,
		MODE_QUOTE = 3'd2,
		MODE_CODE  = 3'd3,
		MODE_SKIP  = 3'd4
	} mode_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       is_last;
	} char_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_out;
		logic       end_of_run;
	} result_item_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] code_accum;
		logic       code_overflow;
		logic       saw_digit;
	} scan_state_t;

	typedef struct packed {
		scan_state_t  next;
		logic [1:0]   n_res;
		result_item_t r0;
		result_item_t r1;
	} step_t;

endpackage

// ===== rtl/qlu_chan_if.sv =====
// valid/ready channel carrying one item
interface qlu_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/quoted_literal_unescaper_unit.sv =====
// quoted literal unescaper: top level with input register and scan state
// Takes one character of a Pascal-style quoted literal per cycle on char_ch
// and gives decoded bytes, a finished result or one error result on result_ch.
// An accepted character is held in the input register, decoded against
// the scan state and its results written into a result queue of
// RESULT_DEPTH entries.
// Input runs at one character per cycle as long as the queue has room for
// two results; a code escape that closes the literal yields two results,
// which leave the output one at a time, and downstream stalls back up
// through the queue.
module quoted_literal_unescaper_unit #(
	parameter int RESULT_DEPTH = qlu_pkg::RESULT_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	qlu_chan_if.sink   char_ch,
	qlu_chan_if.source result_ch
);
	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 last_s1;
	qlu_pkg::scan_state_t state_q;
	qlu_pkg::step_t       step;
	logic                 space_two;
	logic                 advance;

	assign advance = valid_s1 && space_two;
	assign char_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (char_ch.valid && char_ch.ready) begin
			char_s1 <= char_ch.payload.char_in;
			last_s1 <= char_ch.payload.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '{mode: qlu_pkg::MODE_OPEN, code_accum: '0,
				code_overflow: 1'b0, saw_digit: 1'b0};
		end else begin
			if (char_ch.ready) begin
				valid_s1 <= char_ch.valid;
			end
			if (advance) begin
				state_q <= step.next;
			end
		end
	end

	qlu_decode u_decode (
		.char_in (char_s1),
		.is_last (last_s1),
		.st      (state_q),
		.step    (step)
	);

	qlu_result_fifo #(
		.DEPTH (RESULT_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (advance ? step.n_res : 2'd0),
		.push_r0   (step.r0),
		.push_r1   (step.r1),
		.space_two (space_two),
		.result_ch (result_ch)
	);
endmodule

// ===== rtl/qlu_decode.sv =====
// per-character decode: next scan state and up to two results
module qlu_decode (
	input  logic [7:0]           char_in,
	input  logic                 is_last,
	input  qlu_pkg::scan_state_t st,
	output qlu_pkg::step_t       step
);
	logic       is_quote;
	logic       is_hash;
	logic       is_digit;
	logic [11:0] code_val;
	logic       err;
	logic [1:0] n;
	qlu_pkg::scan_state_t nxt;
	qlu_pkg::result_item_t r0;
	qlu_pkg::result_item_t r1;

	assign is_quote = (char_in == qlu_pkg::QUOTE_CH);
	assign is_hash  = (char_in == qlu_pkg::HASH_CH);
	assign is_digit = (char_in >= qlu_pkg::DIGIT_LO) && (char_in <= qlu_pkg::DIGIT_HI);
	// accum * 10 + digit
	assign code_val = {1'b0, st.code_accum, 3'b000} + {3'b000, st.code_accum, 1'b0}
		+ {8'd0, char_in[3:0]};

	always_comb begin
		nxt = st;
		err = 1'b0;
		n   = 2'd0;
		r0  = '0;
		r1  = '0;
		case (st.mode)
			qlu_pkg::MODE_OPEN: begin
				if (!is_quote || is_last) begin
					err = 1'b1;
				end else begin
					nxt.mode = qlu_pkg::MODE_BODY;
				end
			end
			qlu_pkg::MODE_BODY: begin
				if (is_quote) begin
					if (is_last) begin
						r0.kind = qlu_pkg::KIND_DONE;
						n = 2'd1;
					end else begin
						nxt.mode = qlu_pkg::MODE_QUOTE;
					end
				end else if (is_last) begin
					err = 1'b1;
				end else begin
					r0.kind = qlu_pkg::KIND_BYTE;
					r0.byte_out = char_in;
					n = 2'd1;
				end
			end
			qlu_pkg::MODE_QUOTE: begin
				if (is_quote && !is_last) begin
					r0.kind = qlu_pkg::KIND_BYTE;
					r0.byte_out = qlu_pkg::QUOTE_CH;
					n = 2'd1;
					nxt.mode = qlu_pkg::MODE_BODY;
				end else if (is_hash && !is_last) begin
					nxt.code_accum = '0;
					nxt.code_overflow = 1'b0;
					nxt.saw_digit = 1'b0;
					nxt.mode = qlu_pkg::MODE_CODE;
				end else begin
					err = 1'b1;
				end
			end
			qlu_pkg::MODE_CODE: begin
				if (is_digit && !is_last) begin
					if (!st.code_overflow && code_val <= qlu_pkg::CODE_MAX) begin
						nxt.code_accum = code_val[7:0];
					end else begin
						nxt.code_overflow = 1'b1;
					end
					nxt.saw_digit = 1'b1;
				end else if (is_quote && st.saw_digit && !st.code_overflow) begin
					r0.kind = qlu_pkg::KIND_BYTE;
					r0.byte_out = st.code_accum;
					n = 2'd1;
					if (is_last) begin
						r1.kind = qlu_pkg::KIND_DONE;
						n = 2'd2;
					end else begin
						nxt.mode = qlu_pkg::MODE_BODY;
					end
					nxt.code_accum = '0;
					nxt.code_overflow = 1'b0;
					nxt.saw_digit = 1'b0;
				end else begin
					err = 1'b1;
				end
			end
			default: begin
				// skipping: nothing until the last flag
			end
		endcase

		if (err) begin
			r0 = '0;
			r0.kind = qlu_pkg::KIND_ERR;
			n = 2'd1;
			nxt.code_accum = '0;
			nxt.code_overflow = 1'b0;
			nxt.saw_digit = 1'b0;
			nxt.mode = qlu_pkg::MODE_SKIP;
		end
		if (is_last) begin
			nxt.mode = qlu_pkg::MODE_OPEN;
			nxt.code_accum = '0;
			nxt.code_overflow = 1'b0;
			nxt.saw_digit = 1'b0;
		end
		r0.end_of_run = (n == 2'd1);
		r1.end_of_run = 1'b1;

		step.next  = nxt;
		step.n_res = n;
		step.r0    = r0;
		step.r1    = r1;
	end
endmodule

// ===== rtl/qlu_result_fifo.sv =====
// small result queue: takes up to two results per cycle, gives one
module qlu_result_fifo #(
	parameter int DEPTH = qlu_pkg::RESULT_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            push_n,
	input  qlu_pkg::result_item_t push_r0,
	input  qlu_pkg::result_item_t push_r1,
	output logic                  space_two,
	qlu_chan_if.source            result_ch
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

	qlu_pkg::result_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wr_p1;
	logic [PW-1:0] wr_p2;
	logic [PW-1:0] rd_p1;
	logic          pop;

	assign wr_p1 = (wr_q == LAST_IDX) ? '0 : wr_q + PW'(1);
	assign wr_p2 = (wr_p1 == LAST_IDX) ? '0 : wr_p1 + PW'(1);
	assign rd_p1 = (rd_q == LAST_IDX) ? '0 : rd_q + PW'(1);

	assign result_ch.valid   = (count_q != '0);
	assign result_ch.payload = mem_q[rd_q];
	assign pop = result_ch.valid && result_ch.ready;

	// free entries after this cycle's pop must cover two results
	assign space_two = ({1'b0, count_q} + (CW + 1)'(2)) <= (DEPTH_W + {{CW{1'b0}}, pop});

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push_r0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_p1] <= push_r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			case (push_n)
				2'd1: wr_q <= wr_p1;
				2'd2: wr_q <= wr_p2;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= rd_p1;
			end
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end
endmodule

// ===== rtl/qlu_checker.sv =====
// port-level checks of the unescaper and their bind to the top level
module qlu_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  res_valid,
	input logic                  res_ready,
	input qlu_pkg::result_item_t res_payload
);
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_payload))
		else $error("result payload changed while stalled");

	// finished and error results close a run and carry no byte
	a_close_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_payload.kind == qlu_pkg::KIND_DONE
			|| res_payload.kind == qlu_pkg::KIND_ERR)
		|-> res_payload.end_of_run && (res_payload.byte_out == 8'd0))
		else $error("finished or error result malformed");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_payload.kind == qlu_pkg::KIND_BYTE
			|| res_payload.kind == qlu_pkg::KIND_DONE
			|| res_payload.kind == qlu_pkg::KIND_ERR))
		else $error("result kind out of range");
endmodule

bind quoted_literal_unescaper_unit qlu_checker u_qlu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result_ch.valid),
	.res_ready   (result_ch.ready),
	.res_payload (result_ch.payload)
);

// ===== test/testbench.sv =====
// testbench for the quoted literal unescaper unit: literal stimulus, decode prediction, checks
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import qlu_pkg::*;

	localparam int CHAR_TARGET = 1550;
	localparam int HOLD_CYCLES = 60;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 12;

	// tracks the scan state of the unit and the decoded results it still owes
	class literal_scoreboard;
		mode_t        mode;
		logic [7:0]   accum;
		bit           ovf;
		bit           digit_seen;
		result_item_t due_results[$];
		int           n_chars;
		int           n_live;
		int           n_results;
		int           n_done;
		int           n_err;
		int           n_mismatch;

		function new();
			mode = MODE_OPEN;
			clear_code();
		endfunction

		function void clear_code();
			accum = '0;
			ovf = 1'b0;
			digit_seen = 1'b0;
		endfunction

		function result_item_t make_result(logic [1:0] k, logic [7:0] b);
			result_item_t r;
			r.kind = k;
			r.byte_out = b;
			r.end_of_run = 1'b0;
			return r;
		endfunction

		// advance the scan state by one character and queue what it decodes to
		function void take_char(char_item_t it);
			result_item_t res[$];
			logic [7:0]   c;
			bit           last;
			bit           bad;
			int           v;
			c = it.char_in;
			last = it.is_last;
			bad = 1'b0;
			n_chars++;
			if (mode != MODE_SKIP)
				n_live++;
			case (mode)
				MODE_OPEN: begin
					if (c != QUOTE_CH || last)
						bad = 1'b1;
					else
						mode = MODE_BODY;
				end
				MODE_BODY: begin
					if (c == QUOTE_CH) begin
						if (last)
							res.push_back(make_result(KIND_DONE, 8'h00));
						else
							mode = MODE_QUOTE;
					end else if (last) begin
						bad = 1'b1;
					end else begin
						res.push_back(make_result(KIND_BYTE, c));
					end
				end
				MODE_QUOTE: begin
					if (c == QUOTE_CH && !last) begin
						res.push_back(make_result(KIND_BYTE, QUOTE_CH));
						mode = MODE_BODY;
					end else if (c == HASH_CH && !last) begin
						clear_code();
						mode = MODE_CODE;
					end else begin
						bad = 1'b1;
					end
				end
				MODE_CODE: begin
					if (c >= DIGIT_LO && c <= DIGIT_HI && !last) begin
						v = int'(accum) * 10 + int'(c - DIGIT_LO);
						if (!ovf && v <= int'(CODE_MAX))
							accum = v[7:0];
						else
							ovf = 1'b1;
						digit_seen = 1'b1;
					end else if (c == QUOTE_CH && digit_seen && !ovf) begin
						res.push_back(make_result(KIND_BYTE, accum));
						if (last)
							res.push_back(make_result(KIND_DONE, 8'h00));
						else
							mode = MODE_BODY;
						clear_code();
					end else begin
						bad = 1'b1;
					end
				end
				default: ;
			endcase
			if (bad) begin
				res.delete();
				res.push_back(make_result(KIND_ERR, 8'h00));
				clear_code();
				mode = MODE_SKIP;
			end
			if (last) begin
				mode = MODE_OPEN;
				clear_code();
			end
			if (res.size() > 0)
				res[res.size() - 1].end_of_run = 1'b1;
			foreach (res[i])
				due_results.push_back(res[i]);
		endfunction

		task report(string what);
			n_mismatch++;
			$display("mismatch at %0t: %s", $realtime, what);
		endtask

		task check_result(result_item_t got);
			result_item_t want;
			n_results++;
			if (got.kind == KIND_DONE)
				n_done++;
			if (got.kind == KIND_ERR)
				n_err++;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d byte %02h end %0b",
					got.kind, got.byte_out, got.end_of_run));
			end else begin
				want = due_results.pop_front();
				if (got.kind != want.kind)
					report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
				if (got.byte_out != want.byte_out)
					report($sformatf("byte %02h, wanted %02h", got.byte_out, want.byte_out));
				if (got.end_of_run != want.end_of_run)
					report($sformatf("end_of_run %0b, wanted %0b",
						got.end_of_run, want.end_of_run));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	qlu_chan_if #(.payload_t(char_item_t))   char_ch ();
	qlu_chan_if #(.payload_t(result_item_t)) result_ch ();

	quoted_literal_unescaper_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_ch  (char_ch),
		.result_ch(result_ch)
	);

	literal_scoreboard sb = new();

	logic [7:0] text_q[$];
	bit         steady = 1'b0;
	bit         src_push = 1'b0;
	bit         hold_req = 1'b0;
	int         n_literals = 0;
	int         n_holds = 0;
	int         stall_cycles = 0;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_ch.valid && char_ch.ready)
				sb.take_char(char_ch.payload);
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.payload);
		end
	end

	always @(posedge clk) begin
		if ((char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("quoted_literal_unescaper_unit verification failed");
			$finish;
		end
	end

	// result side: random back pressure, plus a long hold when asked for
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				n_holds++;
				hold_req = 1'b0;
			end else begin
				result_ch.ready <= steady || ($urandom_range(99) >= 25);
			end
		end
	end

	task automatic send_char(char_item_t it);
		while (!steady && !src_push && $urandom_range(99) < 25) begin
			char_ch.valid <= 1'b0;
			@(posedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.payload <= it;
		@(posedge clk);
		while (!char_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_text();
		char_item_t it;
		for (int i = 0; i < text_q.size(); i++) begin
			it.char_in = text_q[i];
			it.is_last = (i == text_q.size() - 1);
			send_char(it);
		end
		n_literals++;
	endtask

	function automatic void set_text(string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == QUOTE_CH);
		return c;
	endfunction

	function automatic void push_plain(int n);
		repeat (n) text_q.push_back(plain_char());
	endfunction

	// quote, hash, decimal digits (sometimes zero padded), quote
	function automatic void push_code(int value);
		string s;
		s = $sformatf("%0d", value);
		text_q.push_back(QUOTE_CH);
		text_q.push_back(HASH_CH);
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 3)) text_q.push_back(DIGIT_LO);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		text_q.push_back(QUOTE_CH);
	endfunction

	function automatic void build_good();
		int r;
		text_q.delete();
		text_q.push_back(QUOTE_CH);
		repeat ($urandom_range(0, 10)) begin
			r = $urandom_range(99);
			if (r < 70) begin
				push_plain(1);
			end else if (r < 85) begin
				text_q.push_back(QUOTE_CH);
				text_q.push_back(QUOTE_CH);
			end else begin
				push_code($urandom_range(255));
			end
		end
		// a code escape may close the literal with its own quote
		if ($urandom_range(4) == 0)
			push_code($urandom_range(255));
		else
			text_q.push_back(QUOTE_CH);
	endfunction

	function automatic void build_broken();
		logic [7:0] c;
		case ($urandom_range(6))
			0: begin
				build_good();
				text_q = text_q[0:$urandom_range(0, text_q.size() - 1)];
			end
			1: begin
				build_good();
				text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(255));
			end
			2: begin
				text_q.delete();
				text_q.push_back(QUOTE_CH);
				push_plain($urandom_range(0, 3));
				push_code($urandom_range(256, 99999));
				push_plain($urandom_range(0, 3));
				text_q.push_back(QUOTE_CH);
			end
			3: begin
				set_text("'");
				push_plain($urandom_range(0, 3));
				text_q.push_back(QUOTE_CH);
				text_q.push_back(HASH_CH);
				text_q.push_back(QUOTE_CH);
				push_plain($urandom_range(0, 2));
				text_q.push_back(QUOTE_CH);
			end
			4: begin
				set_text("'");
				push_plain($urandom_range(0, 3));
				text_q.push_back(QUOTE_CH);
				do
					c = 8'($urandom_range(255));
				while (c == QUOTE_CH || c == HASH_CH);
				text_q.push_back(c);
				push_plain($urandom_range(0, 4));
				text_q.push_back(QUOTE_CH);
			end
			5: begin
				text_q.delete();
				repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
			end
			default: begin
				build_good();
				if (text_q.size() > 1)
					void'(text_q.pop_front());
			end
		endcase
	endfunction

	initial begin
		arst_n <= 1'b0;
		char_ch.valid <= 1'b0;
		char_ch.payload <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed literals
		set_text("'");
		send_text();
		set_text("'ab'");
		text_q[1] = 8'h00;
		text_q[2] = 8'hff;
		send_text();
		set_text("'''");
		send_text();
		set_text("''#255'");
		send_text();
		set_text("''#'");
		send_text();
		set_text("''xy");
		send_text();
		set_text("''");
		send_text();

		// random literals, mostly well formed
		while (sb.n_chars < CHAR_TARGET) begin
			steady = (n_literals >= 60 && n_literals < 90);
			if (n_literals == 40 || n_literals == 100) begin
				hold_req = 1'b1;
				src_push = 1'b1;
			end else if (!hold_req) begin
				src_push = 1'b0;
			end
			if ($urandom_range(99) < 75)
				build_good();
			else
				build_broken();
			send_text();
		end
		char_ch.valid <= 1'b0;
		steady = 1'b0;

		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d literals in %0d characters, %0d of them outside error skipping",
			n_literals, sb.n_chars, sb.n_live);
		$display("checked %0d results (%0d finished, %0d errors), %0d long output holds",
			sb.n_results, sb.n_done, sb.n_err, n_holds);
		if (sb.n_mismatch == 0 && sb.due_results.size() == 0)
			$display("quoted_literal_unescaper_unit verification clean");
		else
			$display("quoted_literal_unescaper_unit verification failed");
		$finish;
	end
endmodule
